### rtl/sbcm_pkg.sv
// shared types, constants and command codes of the span buffer clip/merge block
`timescale 1ns / 1ps

package sbcm_pkg;

    localparam int LINES_DEF     = 512;
    localparam int SPL_DEF       = 16;
    localparam int COORD_MAX_DEF = 2048;

    localparam int XW        = 12;
    localparam int LINE_IN_W = 9;
    localparam int RNG_W     = 10;
    localparam int TOT_W     = 14;

    localparam logic [1:0] KIND_MERGE = 2'd0;
    localparam logic [1:0] KIND_CLIP  = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
    localparam logic [OP_W-1:0] OP_CLR     = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd2;
    localparam logic [OP_W-1:0] OP_DEC     = 5'd3;
    localparam logic [OP_W-1:0] OP_M_CNT   = 5'd4;
    localparam logic [OP_W-1:0] OP_M_ARD   = 5'd5;
    localparam logic [OP_W-1:0] OP_M_ACAP  = 5'd6;
    localparam logic [OP_W-1:0] OP_M_ADEC  = 5'd7;
    localparam logic [OP_W-1:0] OP_M_BRD   = 5'd8;
    localparam logic [OP_W-1:0] OP_M_BCAP  = 5'd9;
    localparam logic [OP_W-1:0] OP_M_EMIT2 = 5'd10;
    localparam logic [OP_W-1:0] OP_M_FIN   = 5'd11;
    localparam logic [OP_W-1:0] OP_M_PUSH  = 5'd12;
    localparam logic [OP_W-1:0] OP_C_CNT   = 5'd13;
    localparam logic [OP_W-1:0] OP_C_RD    = 5'd14;
    localparam logic [OP_W-1:0] OP_C_CAP   = 5'd15;
    localparam logic [OP_W-1:0] OP_C_END   = 5'd16;
    localparam logic [OP_W-1:0] OP_R_RD    = 5'd17;
    localparam logic [OP_W-1:0] OP_R_CAP   = 5'd18;
    localparam logic [OP_W-1:0] OP_R_PUSH  = 5'd19;

    typedef struct packed {
        logic [1:0]           kind;
        logic [LINE_IN_W-1:0] line;
        logic [XW-1:0]        x_start;
        logic [XW-1:0]        x_end;
    } item_t;

    typedef struct packed {
        logic             span_valid;
        logic [XW-1:0]    span_begin;
        logic [XW-1:0]    span_finish;
        logic             last;
        logic             overflow;
        logic [RNG_W-1:0] range_first;
        logic [RNG_W-1:0] range_past_last;
        logic [TOT_W-1:0] span_total;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       item_ok;
        logic [1:0] kind;
        logic       r_at_n;
        logic       drop;
        logic       emit2;
        logic       out_free;
        logic       clip_wait;
        logic       scan_last;
    } status_t;

endpackage

### rtl/sbcm_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sbcm_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                  wdata,
    input  logic                          re,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                  rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/sbcm_ctrl.sv
// sequencer state machine of the span buffer clip/merge block
`timescale 1ns / 1ps

module sbcm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  sbcm_pkg::status_t status,
    output sbcm_pkg::cmd_t    cmd,
    output logic              idle
);
    import sbcm_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_CLR     = 5'd0;
    localparam logic [ST_W-1:0] S_IDLE    = 5'd1;
    localparam logic [ST_W-1:0] S_DEC     = 5'd2;
    localparam logic [ST_W-1:0] S_M_CNT   = 5'd3;
    localparam logic [ST_W-1:0] S_M_ARD   = 5'd4;
    localparam logic [ST_W-1:0] S_M_ACAP  = 5'd5;
    localparam logic [ST_W-1:0] S_M_ADEC  = 5'd6;
    localparam logic [ST_W-1:0] S_M_BRD   = 5'd7;
    localparam logic [ST_W-1:0] S_M_BCAP  = 5'd8;
    localparam logic [ST_W-1:0] S_M_EMIT2 = 5'd9;
    localparam logic [ST_W-1:0] S_M_FIN   = 5'd10;
    localparam logic [ST_W-1:0] S_M_PUSH  = 5'd11;
    localparam logic [ST_W-1:0] S_C_CNT   = 5'd12;
    localparam logic [ST_W-1:0] S_C_RD    = 5'd13;
    localparam logic [ST_W-1:0] S_C_CAP   = 5'd14;
    localparam logic [ST_W-1:0] S_C_END   = 5'd15;
    localparam logic [ST_W-1:0] S_R_RD    = 5'd16;
    localparam logic [ST_W-1:0] S_R_CAP   = 5'd17;
    localparam logic [ST_W-1:0] S_R_PUSH  = 5'd18;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.op = OP_DEC;
                case (status.kind)
                    KIND_MERGE: state_next = status.item_ok ? S_M_CNT : S_M_PUSH;
                    KIND_CLIP:  state_next = status.item_ok ? S_C_CNT : S_C_END;
                    KIND_RANGE: state_next = S_R_RD;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_M_CNT:
            begin
                cmd.op     = OP_M_CNT;
                state_next = S_M_ARD;
            end
            S_M_ARD:
            begin
                cmd.op     = OP_M_ARD;
                state_next = status.r_at_n ? S_M_ADEC : S_M_ACAP;
            end
            S_M_ACAP:
            begin
                cmd.op     = OP_M_ACAP;
                state_next = S_M_ARD;
            end
            S_M_ADEC:
            begin
                cmd.op     = OP_M_ADEC;
                state_next = status.drop ? S_M_PUSH : S_M_BRD;
            end
            S_M_BRD:
            begin
                cmd.op     = OP_M_BRD;
                state_next = status.r_at_n ? S_M_FIN : S_M_BCAP;
            end
            S_M_BCAP:
            begin
                cmd.op     = OP_M_BCAP;
                state_next = status.emit2 ? S_M_EMIT2 : S_M_BRD;
            end
            S_M_EMIT2:
            begin
                cmd.op     = OP_M_EMIT2;
                state_next = S_M_BRD;
            end
            S_M_FIN:
            begin
                cmd.op     = OP_M_FIN;
                state_next = S_M_PUSH;
            end
            S_M_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_M_PUSH;
                    state_next = S_IDLE;
                end
            end
            S_C_CNT:
            begin
                cmd.op     = OP_C_CNT;
                state_next = S_C_RD;
            end
            S_C_RD:
            begin
                cmd.op     = OP_C_RD;
                state_next = status.r_at_n ? S_C_END : S_C_CAP;
            end
            S_C_CAP:
            begin
                if (!status.clip_wait)
                begin
                    cmd.op     = OP_C_CAP;
                    state_next = S_C_RD;
                end
            end
            S_C_END:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_C_END;
                    state_next = S_IDLE;
                end
            end
            S_R_RD:
            begin
                cmd.op     = OP_R_RD;
                state_next = S_R_CAP;
            end
            S_R_CAP:
            begin
                cmd.op     = OP_R_CAP;
                state_next = status.scan_last ? S_R_PUSH : S_R_RD;
            end
            S_R_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_R_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);
endmodule

### rtl/sbcm_dp.sv
// datapath: span store, line counts, scratch row, merge/clip/range logic, result register
`timescale 1ns / 1ps

module sbcm_dp #(
    parameter int LINES     = sbcm_pkg::LINES_DEF,
    parameter int SPL       = sbcm_pkg::SPL_DEF,
    parameter int COORD_MAX = sbcm_pkg::COORD_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sbcm_pkg::item_t   item,
    input  sbcm_pkg::cmd_t    cmd,
    output sbcm_pkg::status_t status,
    output sbcm_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);
    import sbcm_pkg::*;

    localparam int DEPTH = LINES * SPL;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int LW    = LINES > 1 ? $clog2(LINES) : 1;
    localparam int YW    = $clog2(LINES + 1);
    localparam int CW    = $clog2(SPL + 1);
    localparam int RW    = $clog2(SPL);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int SW    = 2 * XW;

    logic [1:0]           kind_reg;
    logic [LINE_IN_W-1:0] line_reg;
    logic [XW-1:0]        a_reg, b_reg;
    logic [CW-1:0]        n_reg, r_reg, w_reg;
    logic                 touch_reg, placed_reg, ovf_reg;
    logic [XW-1:0]        cur_b_reg, cur_f_reg, hold_b_reg, hold_f_reg;
    logic                 pend_valid_reg;
    logic [XW-1:0]        pend_b_reg, pend_f_reg;
    logic [YW-1:0]        y_reg, first_reg, past_reg;
    logic                 found_reg;
    logic [TW-1:0]        total_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    logic [LW-1:0] line_idx;
    logic          line_ok, item_ok;
    logic [AW-1:0] base, rd_addr, wr_addr;
    logic [SW-1:0] main_rdata, main_wdata, scr_rdata;
    logic          main_we, main_re, scr_re, scr_we;
    logic [CW-1:0] cnt_rdata, cnt_wdata, w_fin;
    logic          cnt_we, cnt_re;
    logic [LW-1:0] cnt_waddr, cnt_raddr;
    logic [XW-1:0] s_b, s_f, t_b, t_f, clip_b, clip_f;
    logic          hit, b_absorb, b_insert, out_free, push;
    result_t       res_new;
    logic [XW-1:0] sat_a, sat_b;

    assign line_idx = LW'(line_reg);
    assign line_ok  = 32'(line_reg) < LINES;
    assign item_ok  = line_ok && (b_reg > a_reg);
    assign base     = AW'(32'(line_idx) * SPL);
    assign rd_addr  = base + AW'(r_reg[RW-1:0]);
    assign wr_addr  = base + AW'(w_reg[RW-1:0]);
    assign w_fin    = w_reg + CW'(!placed_reg);

    // saturate incoming coordinates
    assign sat_a = (32'(item.x_start) > COORD_MAX) ? XW'(COORD_MAX) : item.x_start;
    assign sat_b = (32'(item.x_end) > COORD_MAX) ? XW'(COORD_MAX) : item.x_end;

    assign s_b = main_rdata[SW-1:XW];
    assign s_f = main_rdata[XW-1:0];
    assign t_b = scr_rdata[SW-1:XW];
    assign t_f = scr_rdata[XW-1:0];

    // clip of one stored span against the raster
    assign hit    = (s_f > a_reg) && (s_b < b_reg);
    assign clip_b = (s_b > a_reg) ? s_b : a_reg;
    assign clip_f = (s_f < b_reg) ? s_f : b_reg;

    // merge decision for one span from the scratch row
    assign b_absorb = !placed_reg && !(t_f < cur_b_reg) && (t_b <= cur_f_reg);
    assign b_insert = !placed_reg && !(t_f < cur_b_reg) && !(t_b <= cur_f_reg);

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        main_re    = ((cmd.op == OP_M_ARD) || (cmd.op == OP_C_RD)) && (r_reg != n_reg);
        main_we    = 1'b0;
        main_wdata = scr_rdata;
        case (cmd.op)
            OP_M_BCAP:
            begin
                main_we    = !b_absorb;
                main_wdata = b_insert ? {cur_b_reg, cur_f_reg} : scr_rdata;
            end
            OP_M_EMIT2:
            begin
                main_we    = 1'b1;
                main_wdata = {hold_b_reg, hold_f_reg};
            end
            OP_M_FIN:
            begin
                main_we    = !placed_reg;
                main_wdata = {cur_b_reg, cur_f_reg};
            end
            default:
            begin
                main_we = 1'b0;
            end
        endcase
    end

    assign scr_we = (cmd.op == OP_M_ACAP);
    assign scr_re = (cmd.op == OP_M_BRD) && (r_reg != n_reg);

    assign cnt_re    = (cmd.op == OP_DEC) || (cmd.op == OP_R_RD);
    assign cnt_raddr = (cmd.op == OP_R_RD) ? y_reg[LW-1:0] : line_idx;
    assign cnt_we    = (cmd.op == OP_CLR) || (cmd.op == OP_M_FIN);
    assign cnt_waddr = (cmd.op == OP_CLR) ? y_reg[LW-1:0] : line_idx;
    assign cnt_wdata = (cmd.op == OP_CLR) ? '0 : w_fin;

    sbcm_ram #(.W(SW), .D(DEPTH)) u_store (
        .clk   (clk),
        .we    (main_we),
        .waddr (wr_addr),
        .wdata (main_wdata),
        .re    (main_re),
        .raddr (rd_addr),
        .rdata (main_rdata)
    );

    sbcm_ram #(.W(SW), .D(SPL)) u_scratch (
        .clk   (clk),
        .we    (scr_we),
        .waddr (r_reg[RW-1:0]),
        .wdata (main_rdata),
        .re    (scr_re),
        .raddr (r_reg[RW-1:0]),
        .rdata (scr_rdata)
    );

    sbcm_ram #(.W(CW), .D(LINES)) u_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        res_new = '0;
        push    = 1'b0;
        case (cmd.op)
            OP_M_PUSH:
            begin
                push             = 1'b1;
                res_new.last     = 1'b1;
                res_new.overflow = ovf_reg;
            end
            OP_C_CAP:
            begin
                push                = hit && pend_valid_reg;
                res_new.span_valid  = 1'b1;
                res_new.span_begin  = pend_b_reg;
                res_new.span_finish = pend_f_reg;
            end
            OP_C_END:
            begin
                push                = 1'b1;
                res_new.span_valid  = pend_valid_reg;
                res_new.span_begin  = pend_valid_reg ? pend_b_reg : '0;
                res_new.span_finish = pend_valid_reg ? pend_f_reg : '0;
                res_new.last        = 1'b1;
            end
            OP_R_PUSH:
            begin
                push                    = 1'b1;
                res_new.last            = 1'b1;
                res_new.range_first     = found_reg ? RNG_W'(first_reg) : '0;
                res_new.range_past_last = RNG_W'(past_reg);
                res_new.span_total      = TOT_W'(total_reg);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= '0;
            line_reg       <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            n_reg          <= '0;
            r_reg          <= '0;
            w_reg          <= '0;
            touch_reg      <= 1'b0;
            placed_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
            cur_b_reg      <= '0;
            cur_f_reg      <= '0;
            hold_b_reg     <= '0;
            hold_f_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_b_reg     <= '0;
            pend_f_reg     <= '0;
            y_reg          <= '0;
            first_reg      <= '0;
            past_reg       <= '0;
            found_reg      <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_CLR:
                begin
                    y_reg <= y_reg + YW'(1);
                end
                OP_LOAD:
                begin
                    kind_reg <= item.kind;
                    line_reg <= item.line;
                    a_reg    <= sat_a;
                    b_reg    <= sat_b;
                end
                OP_DEC:
                begin
                    ovf_reg        <= 1'b0;
                    pend_valid_reg <= 1'b0;
                    y_reg          <= '0;
                    found_reg      <= 1'b0;
                    first_reg      <= '0;
                    past_reg       <= '0;
                end
                OP_M_CNT:
                begin
                    n_reg     <= cnt_rdata;
                    r_reg     <= '0;
                    touch_reg <= 1'b0;
                end
                OP_M_ACAP:
                begin
                    touch_reg <= touch_reg || ((s_f >= a_reg) && (s_b <= b_reg));
                    r_reg     <= r_reg + CW'(1);
                end
                OP_M_ADEC:
                begin
                    ovf_reg    <= !touch_reg && (32'(n_reg) == SPL);
                    r_reg      <= '0;
                    w_reg      <= '0;
                    cur_b_reg  <= a_reg;
                    cur_f_reg  <= b_reg;
                    placed_reg <= 1'b0;
                end
                OP_M_BCAP:
                begin
                    r_reg <= r_reg + CW'(1);
                    if (b_absorb)
                    begin
                        cur_b_reg <= (t_b < cur_b_reg) ? t_b : cur_b_reg;
                        cur_f_reg <= (t_f > cur_f_reg) ? t_f : cur_f_reg;
                    end
                    else
                    begin
                        w_reg <= w_reg + CW'(1);
                    end
                    if (b_insert)
                    begin
                        placed_reg <= 1'b1;
                        hold_b_reg <= t_b;
                        hold_f_reg <= t_f;
                    end
                end
                OP_M_EMIT2:
                begin
                    w_reg <= w_reg + CW'(1);
                end
                OP_M_FIN:
                begin
                    total_reg <= total_reg - TW'(n_reg) + TW'(w_fin);
                end
                OP_C_CNT:
                begin
                    n_reg <= cnt_rdata;
                    r_reg <= '0;
                end
                OP_C_CAP:
                begin
                    r_reg <= r_reg + CW'(1);
                    if (hit)
                    begin
                        pend_valid_reg <= 1'b1;
                        pend_b_reg     <= clip_b;
                        pend_f_reg     <= clip_f;
                    end
                end
                OP_C_END:
                begin
                    pend_valid_reg <= 1'b0;
                end
                OP_R_CAP:
                begin
                    if (cnt_rdata != '0)
                    begin
                        if (!found_reg)
                        begin
                            first_reg <= y_reg;
                        end
                        found_reg <= 1'b1;
                        past_reg  <= y_reg + YW'(1);
                    end
                    y_reg <= y_reg + YW'(1);
                end
                default:
                begin
                    kind_reg <= kind_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (push)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_new;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign status.clr_last  = (32'(y_reg) == LINES - 1);
    assign status.item_ok   = item_ok;
    assign status.kind      = kind_reg;
    assign status.r_at_n    = (r_reg == n_reg);
    assign status.drop      = !touch_reg && (32'(n_reg) == SPL);
    assign status.emit2     = b_insert;
    assign status.out_free  = out_free;
    assign status.clip_wait = hit && pend_valid_reg && !out_free;
    assign status.scan_last = (32'(y_reg) == LINES - 1);

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed while output register is held");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= DEPTH)
        else $error("span total exceeds store depth");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_M_CNT) |=> (32'(n_reg) <= SPL))
        else $error("line count read beyond per-line limit");

    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(w_reg) <= SPL)
        else $error("merge write pointer beyond per-line limit");
endmodule

### rtl/span_buffer_clip_merge_core.sv
// top level of the span buffer clip/merge block
`timescale 1ns / 1ps

// span buffer: per scanline a sorted list of disjoint spans, merged and clipped on request
// input channel item/item_valid/item_stall carries one request: merge, clip or range query
// output channel result/result_valid/result_stall carries the result items of each request
// one request at a time; item_stall is high from acceptance until the last result is
// handed to the output register, which then holds it while the receiver stalls
// merge: copy the line (n stored spans) into a scratch row and check for room, then write
// the merged list back and push the single result with overflow; a dropped merge pushes
// right after the room check
// clip: one store read per stored span; results leave one by one, the last one marked,
// or a single empty result when nothing meets the raster
// range query: one sweep over the line count memory
// the span store and scratch row are single-write, single-read rams; their registered
// read gives each span a read state and a capture state
// after reset the line count memory is cleared, one line per cycle; item_stall stays
// high during that pass
// a stalled receiver only holds the output register; the block waits before its next push

module span_buffer_clip_merge_core #(
    parameter int LINES     = sbcm_pkg::LINES_DEF,
    parameter int SPL       = sbcm_pkg::SPL_DEF,
    parameter int COORD_MAX = sbcm_pkg::COORD_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sbcm_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_stall,
    output sbcm_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);
    import sbcm_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    idle;

    // sequencer: one state per ram step of each request type
    sbcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .status     (status),
        .cmd        (cmd),
        .idle       (idle)
    );

    // store, counts and result register
    sbcm_dp #(
        .LINES     (LINES),
        .SPL       (SPL),
        .COORD_MAX (COORD_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // requests are taken only in the idle state
    assign item_stall = !idle;
endmodule

### sim/span_buffer_clip_merge_checker.sv
// checker: watches both channels of the span buffer, predicts results and compares them
`timescale 1ns / 1ps

module span_buffer_clip_merge_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  sbcm_pkg::item_t   item,
    input  logic              item_valid,
    input  logic              item_stall,
    input  sbcm_pkg::result_t result,
    input  logic              result_valid,
    input  logic              result_stall,
    output int                fail_count,
    output int                pending_count
);
    import sbcm_pkg::*;

    localparam int NLINES = LINES_DEF;
    localparam int SPL    = SPL_DEF;

    logic [XW-1:0]    span_lo [NLINES][SPL];
    logic [XW-1:0]    span_hi [NLINES][SPL];
    int               line_fill [NLINES];
    logic [TOT_W-1:0] store_total;
    result_t          awaited [$];

    function automatic logic [XW-1:0] clamp_coord(logic [XW-1:0] v);
        return (v > COORD_MAX_DEF) ? XW'(COORD_MAX_DEF) : v;
    endfunction

    function automatic result_t blank_result();
        result_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // returns 1 when the span is dropped because the line is full
    function automatic logic merge_span(int ln, logic [XW-1:0] a, logic [XW-1:0] b);
        int n, i, j, k, removed;
        logic [XW-1:0] nb, nf;
        n = line_fill[ln];
        i = 0;
        while (i < n && span_hi[ln][i] < a) i++;
        j = i;
        while (j < n && span_lo[ln][j] <= b) j++;
        if (i == j)
        begin
            if (n >= SPL) return 1'b1;
            for (k = n; k > i; k--)
            begin
                span_lo[ln][k] = span_lo[ln][k-1];
                span_hi[ln][k] = span_hi[ln][k-1];
            end
            span_lo[ln][i] = a;
            span_hi[ln][i] = b;
            line_fill[ln] = n + 1;
            store_total++;
            return 1'b0;
        end
        nb = span_lo[ln][i] < a ? span_lo[ln][i] : a;
        nf = span_hi[ln][j-1] > b ? span_hi[ln][j-1] : b;
        span_lo[ln][i] = nb;
        span_hi[ln][i] = nf;
        removed = j - i - 1;
        for (k = i + 1; k + removed < n; k++)
        begin
            span_lo[ln][k] = span_lo[ln][k+removed];
            span_hi[ln][k] = span_hi[ln][k+removed];
        end
        line_fill[ln] = n - removed;
        store_total -= removed;
        return 1'b0;
    endfunction

    task automatic predict_request(item_t it);
        logic [XW-1:0] a, b;
        result_t r;
        int ln, cnt, first, past;
        a  = clamp_coord(it.x_start);
        b  = clamp_coord(it.x_end);
        ln = it.line;
        r  = blank_result();
        case (it.kind)
            KIND_MERGE:
            begin
                if (ln < NLINES && b > a) r.overflow = merge_span(ln, a, b);
                awaited.push_back(r);
            end
            KIND_CLIP:
            begin
                cnt = 0;
                if (ln < NLINES && b > a)
                begin
                    for (int s = 0; s < line_fill[ln]; s++)
                    begin
                        if (!(span_hi[ln][s] <= a || span_lo[ln][s] >= b))
                        begin
                            r = '0;
                            r.span_valid  = 1'b1;
                            r.span_begin  = span_lo[ln][s] > a ? span_lo[ln][s] : a;
                            r.span_finish = span_hi[ln][s] < b ? span_hi[ln][s] : b;
                            awaited.push_back(r);
                            cnt++;
                        end
                    end
                end
                if (cnt == 0) awaited.push_back(blank_result());
                else awaited[$].last = 1'b1;
            end
            KIND_RANGE:
            begin
                first = 0;
                past  = 0;
                if (store_total != 0)
                begin
                    first = -1;
                    for (int y = 0; y < NLINES; y++)
                    begin
                        if (line_fill[y] != 0)
                        begin
                            if (first < 0) first = y;
                            past = y + 1;
                        end
                    end
                    if (first < 0) first = 0;
                end
                r.range_first     = RNG_W'(first);
                r.range_past_last = RNG_W'(past);
                r.span_total      = store_total;
                awaited.push_back(r);
            end
            default: ;
        endcase
    endtask

    assign pending_count = awaited.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fail_count  <= 0;
            store_total = '0;
            awaited.delete();
            for (int y = 0; y < NLINES; y++) line_fill[y] = 0;
        end
        else
        begin
            if (item_valid && !item_stall) predict_request(item);
            if (result_valid && !result_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (want !== result)
                    begin
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, want, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### sim/span_buffer_clip_merge_core_tb.sv
// testbench top: drives requests into the span buffer and reports the verdict
`timescale 1ns / 1ps

module span_buffer_clip_merge_core_tb;
    import sbcm_pkg::*;

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;
    int      fail_count;
    int      pending_count;
    logic    hold_off_now;

    span_buffer_clip_merge_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    span_buffer_clip_merge_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .result        (result),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous limit: covers range queries over all lines and stalled clips of up to 16 results
    initial
    begin
        #20ms;
        $display("span_buffer_clip_merge_core verification failed");
        $finish;
    end

    // hand one request to the block: random gap, then hold until accepted
    task automatic send_request(logic [1:0] k, int ln, int xs, int xe);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge clk);
        item.kind    = k;
        item.line    = LINE_IN_W'(ln);
        item.x_start = XW'(xs);
        item.x_end   = XW'(xe);
        item_valid   = 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // receiver: random stall per result, one long hold-off early in the random part
    initial
    begin
        int waits;
        logic held;
        result_stall = 1'b1;
        held         = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_now && !held)
            begin
                // long hold-off while the sender keeps offering requests
                held         = 1'b1;
                result_stall = 1'b1;
                repeat (300) @(negedge clk);
            end
            waits = $urandom_range(0, 3);
            result_stall = 1'b1;
            repeat (waits) @(negedge clk);
            result_stall = 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    initial
    begin
        int k, ln, xs, xe, hot;
        rst_n        = 1'b0;
        item         = '0;
        item_valid   = 1'b0;
        hold_off_now = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, extremes, merges that join and touch, full line
        send_request(KIND_RANGE, 0, 0, 0);
        send_request(KIND_CLIP, 3, 0, 2048);
        send_request(KIND_MERGE, 3, 100, 200);
        send_request(KIND_MERGE, 3, 300, 400);
        send_request(KIND_MERGE, 3, 200, 300);            // touches both sides, joins
        send_request(KIND_MERGE, 3, 50, 50);              // empty span
        send_request(KIND_MERGE, 3, 4095, 4000);          // empty after saturation
        send_request(KIND_MERGE, 511, 0, 4095);           // end saturates to max
        send_request(KIND_MERGE, 0, 2047, 2048);
        send_request(KIND_CLIP, 3, 150, 350);
        send_request(KIND_CLIP, 3, 500, 400);             // empty raster
        send_request(KIND_CLIP, 3, 500, 600);             // meets nothing
        send_request(KIND_CLIP, 511, 3000, 4095);         // saturated raster, empty
        send_request(2'd3, 7, 4095, 4095);                // unused kind
        for (int s = 0; s < 17; s++)
            send_request(KIND_MERGE, 5, s * 10, s * 10 + 5);  // last one overflows
        send_request(KIND_MERGE, 5, 400, 410);            // full, disjoint
        send_request(KIND_MERGE, 5, 0, 2048);             // full, swallows all
        send_request(KIND_CLIP, 5, 0, 4095);
        send_request(KIND_RANGE, 0, 0, 0);

        // random: mostly a few hot lines so lists fill, merge and clip deeply
        for (int n = 0; n < 65; n++)
        begin
            if (n == 10) hold_off_now = 1'b1;
            k   = $urandom_range(0, 9);
            hot = $urandom_range(0, 3);
            ln  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : 8 + hot;
            if ($urandom_range(0, 5) == 0)
            begin
                xs = $urandom_range(0, 4095);
                xe = $urandom_range(0, 4095);
            end
            else
            begin
                xs = $urandom_range(0, 2000);
                xe = xs + $urandom_range(0, 60);
            end
            if (k < 5)       send_request(KIND_MERGE, ln, xs, xe);
            else if (k < 8)  send_request(KIND_CLIP, ln, xs, xe);
            else if (k == 8) send_request(KIND_RANGE, ln, xs, xe);
            else             send_request(2'd3, ln, xs, xe);
        end

        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("span_buffer_clip_merge_core verification clean");
        else
            $display("span_buffer_clip_merge_core verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/sbcm_pkg.sv
rtl/sbcm_ram.sv
rtl/sbcm_ctrl.sv
rtl/sbcm_dp.sv
rtl/span_buffer_clip_merge_core.sv
sim/span_buffer_clip_merge_checker.sv
sim/span_buffer_clip_merge_core_tb.sv
